/* hdl/fekc_pkg.sv */
// Shared types and constants for the FIFO-evicting key cache.
// Used by the controller, the datapath and the top level.
`default_nettype none

package fekc_pkg;

    localparam int KEY_W   = 64;
    localparam int BYTES_W = 41;
    localparam int OUT_HANDLE_W = 32;
    localparam int IN_TDATA_W  = 208;
    localparam int OUT_TDATA_W = 160;
    localparam int CFG_IDX_W   = 2;

    localparam logic [1:0] MODE_FIND   = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_ERASE  = 2'd2;
    localparam logic [1:0] MODE_NOP    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECORD_STATS = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input transaction
        logic rd_head;    // read slot at head (else at scan pointer)
        logic evict;      // retire head entry
        logic scan_init;  // scan pointer to head, remaining to count
        logic step;       // advance scan
        logic hit;        // key matched at scan pointer
        logic miss;       // find missed
        logic append;     // write new entry at tail
        logic finish;     // load output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] mode;
        logic       reject;
        logic       need_evict;
        logic       scan_empty;
        logic       match;
        logic       out_free;
    } t_stat;

endpackage

`default_nettype wire

/* hdl/fekc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fekc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hdl/fekc_ctrl.sv */
// Sequencing state machine of the key cache: eviction loop and key scan.
// Depends on fekc_pkg.
`default_nettype none

module fekc_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire fekc_pkg::t_stat i_stat,
    output fekc_pkg::t_cmd       o_cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CHK    = 7'b0000010,
        ST_EV_RD  = 7'b0000100,
        ST_EV_DO  = 7'b0001000,
        ST_SC_RD  = 7'b0010000,
        ST_SC_CMP = 7'b0100000,
        ST_DONE   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHK;
                end
            end
            ST_CHK: begin
                if (i_stat.mode == fekc_pkg::MODE_FIND ||
                    i_stat.mode == fekc_pkg::MODE_ERASE) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = ST_SC_RD;
                end else if (i_stat.mode == fekc_pkg::MODE_INSERT) begin
                    if (i_stat.reject) begin
                        n_state = ST_DONE;
                    end else if (i_stat.need_evict) begin
                        n_state = ST_EV_RD;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = ST_SC_RD;
                    end
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_EV_RD: begin
                o_cmd.rd_head = 1'b1;
                n_state       = ST_EV_DO;
            end
            ST_EV_DO: begin
                o_cmd.evict = 1'b1;
                n_state     = ST_CHK;
            end
            ST_SC_RD: begin
                if (i_stat.scan_empty) begin
                    o_cmd.miss   = (i_stat.mode == fekc_pkg::MODE_FIND);
                    o_cmd.append = (i_stat.mode == fekc_pkg::MODE_INSERT);
                    n_state      = ST_DONE;
                end else begin
                    n_state = ST_SC_CMP;
                end
            end
            ST_SC_CMP: begin
                if (i_stat.match) begin
                    o_cmd.hit = 1'b1;
                    n_state   = ST_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = ST_SC_RD;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/fekc_dp.sv */
// Datapath of the key cache: slot RAMs, mapped bits, ring pointers, byte
// total, statistics, config registers and output register. Uses fekc_pkg, fekc_ram.
`default_nettype none

module fekc_dp #(
    parameter int RING_SLOTS  = 256,
    parameter int HANDLE_BITS = 32
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [fekc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [fekc_pkg::BYTES_W-1:0]          i_cfg_data,
    input  wire logic [1:0]                            i_in_user,
    input  wire logic [fekc_pkg::IN_TDATA_W-1:0]       i_in_data,
    input  wire fekc_pkg::t_cmd                        i_cmd,
    output fekc_pkg::t_stat                            o_stat,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic [fekc_pkg::OUT_TDATA_W-1:0]           o_out_data,
    output logic                                       o_out_user
);

    localparam int PTR_W = $clog2(RING_SLOTS);
    localparam int LIM_W = (PTR_W > 8) ? PTR_W : 8;
    localparam int HST_W = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
    localparam int KW    = fekc_pkg::KEY_W;
    localparam int BW    = fekc_pkg::BYTES_W;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_SLOTS - 1);

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        ring_next = (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    // config
    logic [7:0]    r_entry_limit;
    logic [BW-1:0] r_byte_limit;
    logic          r_record;

    // captured transaction
    logic [1:0]       r_mode;
    logic [KW-1:0]    r_fk, r_lk;
    logic [BW-1:0]    r_bytes;
    logic [HST_W-1:0] r_handle;

    // ring state
    logic [RING_SLOTS-1:0] r_mapped;
    logic [PTR_W-1:0] r_head, r_tail, r_count, r_sp, r_rem;
    logic [BW-1:0]    r_used;
    logic [31:0]      r_hits, r_misses;

    // per-transaction result
    logic             r_ok;
    logic [HST_W-1:0] r_found;
    logic [7:0]       r_evicted;

    // output register
    logic                               r_out_valid;
    logic [fekc_pkg::OUT_TDATA_W-1:0]   r_out_data;
    logic                               r_out_user;

    // slot RAMs
    logic [PTR_W-1:0]  w_raddr;
    logic [2*KW-1:0]   w_key_rd;
    logic [BW-1:0]     w_size_rd;
    logic [HST_W-1:0]  w_handle_rd;

    assign w_raddr = i_cmd.rd_head ? r_head : r_sp;

    fekc_ram #(.WIDTH(2*KW), .DEPTH(RING_SLOTS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.append),
        .i_waddr (r_tail),
        .i_wdata ({r_lk, r_fk}),
        .i_raddr (w_raddr),
        .o_rdata (w_key_rd)
    );

    fekc_ram #(.WIDTH(BW), .DEPTH(RING_SLOTS)) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.append),
        .i_waddr (r_tail),
        .i_wdata (r_bytes),
        .i_raddr (w_raddr),
        .o_rdata (w_size_rd)
    );

    fekc_ram #(.WIDTH(HST_W), .DEPTH(RING_SLOTS)) u_handle_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.append),
        .i_waddr (r_tail),
        .i_wdata (r_handle),
        .i_raddr (w_raddr),
        .o_rdata (w_handle_rd)
    );

    // budget checks
    logic [LIM_W-1:0] w_lim_el, w_lim_cap, w_lim, w_cnt;
    logic [BW:0]      w_sum;
    logic             w_over;
    logic             w_out_free;

    assign w_lim_el  = LIM_W'(r_entry_limit);
    assign w_lim_cap = LIM_W'(RING_SLOTS - 1);
    assign w_lim     = (w_lim_el > w_lim_cap) ? w_lim_cap : w_lim_el;
    assign w_cnt     = LIM_W'(r_count);
    assign w_sum     = {1'b0, r_used} + {1'b0, r_bytes};
    assign w_over    = w_sum > {1'b0, r_byte_limit};
    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_stat.mode       = r_mode;
    assign o_stat.reject     = (r_bytes > r_byte_limit) || (r_entry_limit == 8'd0);
    assign o_stat.need_evict = (r_count != '0) && ((w_cnt >= w_lim) || w_over);
    assign o_stat.scan_empty = (r_rem == '0);
    assign o_stat.match      = r_mapped[r_sp] && (w_key_rd == {r_lk, r_fk});
    assign o_stat.out_free   = w_out_free;

    // payload captures, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_in_user;
            r_fk     <= i_in_data[KW-1:0];
            r_lk     <= i_in_data[2*KW-1:KW];
            r_bytes  <= i_in_data[2*KW+BW-1:2*KW];
            r_handle <= HST_W'(i_in_data[2*KW+BW+31:2*KW+BW]);
        end
        if (i_cmd.finish) begin
            r_out_user <= r_ok;
            r_out_data <= {7'd0, r_misses, r_hits, r_used, w_cnt[7:0], r_evicted,
                           32'(r_found)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_limit <= 8'd255;
            r_byte_limit  <= BW'(64'd1073741824);
            r_record      <= 1'b0;
            r_mapped      <= '0;
            r_head        <= '0;
            r_tail        <= '0;
            r_count       <= '0;
            r_sp          <= '0;
            r_rem         <= '0;
            r_used        <= '0;
            r_hits        <= '0;
            r_misses      <= '0;
            r_ok          <= 1'b0;
            r_found       <= '0;
            r_evicted     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    fekc_pkg::REG_ENTRY_LIMIT:  r_entry_limit <= i_cfg_data[7:0];
                    fekc_pkg::REG_BYTE_LIMIT:   r_byte_limit  <= i_cfg_data;
                    fekc_pkg::REG_RECORD_STATS: begin
                        r_record <= i_cfg_data[0];
                        r_hits   <= '0;
                        r_misses <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load) begin
                r_ok      <= 1'b0;
                r_found   <= '0;
                r_evicted <= '0;
            end
            if (i_cmd.evict) begin
                r_used           <= (r_used >= w_size_rd) ? r_used - w_size_rd : '0;
                r_mapped[r_head] <= 1'b0;
                r_head           <= ring_next(r_head);
                r_count          <= r_count - 1'b1;
                r_evicted        <= r_evicted + 8'd1;
            end
            if (i_cmd.scan_init) begin
                r_sp  <= r_head;
                r_rem <= r_count;
            end
            if (i_cmd.step) begin
                r_sp  <= ring_next(r_sp);
                r_rem <= r_rem - 1'b1;
            end
            if (i_cmd.hit) begin
                if (r_mode == fekc_pkg::MODE_FIND) begin
                    r_ok    <= 1'b1;
                    r_found <= w_handle_rd;
                    if (r_record && r_hits != '1) begin
                        r_hits <= r_hits + 32'd1;
                    end
                end else if (r_mode == fekc_pkg::MODE_ERASE) begin
                    r_ok           <= 1'b1;
                    r_mapped[r_sp] <= 1'b0;
                end
            end
            if (i_cmd.miss && r_record && r_misses != '1) begin
                r_misses <= r_misses + 32'd1;
            end
            if (i_cmd.append) begin
                r_mapped[r_tail] <= 1'b1;
                r_tail           <= ring_next(r_tail);
                r_count          <= r_count + 1'b1;
                r_used           <= w_sum[BW-1:0];
                r_ok             <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;

endmodule

`default_nettype wire

/* hdl/fifo_evicting_key_cache.sv */
// Top level of the FIFO-evicting key cache: controller plus datapath.
// Depends on fekc_pkg, fekc_ctrl, fekc_dp (and fekc_ram below it).
//
//  channel   dir  handshake                      payload
//  s (in)    in   i_s_tvalid / o_s_tready        tuser: mode; tdata: key, bytes, handle
//  m (out)   out  o_m_tvalid / i_m_tready        tuser: ok; tdata: result fields
//  cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// One transaction at a time. Find/erase/insert scan slots from the head, up to
// the ring count, before the result; a rejected insert or the unused mode goes
// straight to the result. Each eviction (head read, retire, recheck) comes before
// the scan. The registered slot RAM read splits each scan step into read and compare
// states. The next transaction is taken in the cycle after the result is loaded.
// The output register holds a result while the next transaction is taken; a result
// still waiting there stalls the next one in its final state.
// Reset clears pointers, mapped bits and counters and sets config to its defaults; no RAM clearing.
`default_nettype none

module fifo_evicting_key_cache #(
    parameter int RING_SLOTS  = 256,
    parameter int HANDLE_BITS = 32
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_s_tvalid,
    output logic                                       o_s_tready,
    // [63:0] file key, [127:64] location key, [168:128] item_bytes,
    // [200:169] value_handle, [207:201] zero
    input  wire logic [fekc_pkg::IN_TDATA_W-1:0]       i_s_tdata,
    // [1:0] mode
    input  wire logic [1:0]                            i_s_tuser,
    output logic                                       o_m_tvalid,
    input  wire logic                                  i_m_tready,
    // [31:0] found_handle, [39:32] evicted_count, [47:40] entry_count,
    // [88:48] used_bytes, [120:89] hits, [152:121] misses, [159:153] zero
    output logic [fekc_pkg::OUT_TDATA_W-1:0]           o_m_tdata,
    // [0] ok
    output logic                                       o_m_tuser,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [fekc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [fekc_pkg::BYTES_W-1:0]          i_cfg_data
);

    fekc_pkg::t_cmd  w_cmd;
    fekc_pkg::t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    fekc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    fekc_dp #(
        .RING_SLOTS  (RING_SLOTS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_user   (i_s_tuser),
        .i_in_data   (i_s_tdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out_data  (o_m_tdata),
        .o_out_user  (o_m_tuser)
    );

endmodule

`default_nettype wire

/* hdl/fekc_checker.sv */
// Port-level checks for fifo_evicting_key_cache, bound to the top level.
// Depends on fekc_pkg.
`default_nettype none

module fekc_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_s_tvalid,
    input wire logic                              o_s_tready,
    input wire logic                              o_m_tvalid,
    input wire logic                              i_m_tready,
    input wire logic [fekc_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    input wire logic                              o_m_tuser
);

    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("new transaction taken while one is in flight");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    a_handle_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[31:0] != 32'd0 |-> o_m_tuser)
        else $error("handle reported without a hit");

endmodule

bind fifo_evicting_key_cache fekc_checker u_fekc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
